/* rtl/rectangle_staple_accumulator_assert.svh */
// ----------------------------------------------------------------------------
// Rectangle staple accumulator assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_STAPLE_ACCUMULATOR_ASSERT_SVH
`define RECTANGLE_STAPLE_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RSA_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define RSA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define RSA_ASSERT(lbl, ck, rs, prop, msg)
`define RSA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

/* rtl/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// Rectangle staple accumulator package
// Sizes, number format helpers and shared types.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int NCOL      = 3;
  localparam int DIM       = 4;
  localparam int NSITES    = 256;
  localparam int FRAC_BITS = 20;

  localparam int NSQ    = NCOL * NCOL;
  localparam int VW     = 24;
  localparam int EW     = $clog2(NSQ);
  localparam int IW     = $clog2(NCOL);
  localparam int SW     = 52;
  localparam int SSW    = VW + 2;
  localparam int SITE_W = $clog2(NSITES);
  localparam int DIR_W  = $clog2(DIM);
  localparam int LK_AW  = $clog2(2 * DIM * NSITES * NSQ);
  localparam int NB_AW  = $clog2(2 * DIM * NSITES);

  localparam logic [1:0] OP_LINK   = 2'd0;
  localparam logic [1:0] OP_NBR    = 2'd1;
  localparam logic [1:0] OP_COMP   = 2'd2;
  localparam logic [1:0] OP_PRESET = 2'd3;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = SW'(VMAX);
  localparam logic signed [SW-1:0] SMIN = SW'(VMIN);
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [VW-1:0] re;
    logic signed [VW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic          v;
    logic          first;
    logic          last;
    logic          final_term;
    logic [EW-1:0] dest;
  } mac_tag_t;

  function automatic logic signed [VW-1:0] sat_q(input logic signed [SW-1:0] x);
    logic signed [VW-1:0] r;
    if (x > SMAX) r = VMAX;
    else if (x < SMIN) r = VMIN;
    else r = x[VW-1:0];
    return r;
  endfunction

  function automatic logic signed [VW-1:0] rnd_q(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    t = (x + RND_HALF) >>> FRAC_BITS;
    return sat_q(t);
  endfunction

  function automatic logic signed [VW-1:0] neg_sat(input logic signed [VW-1:0] x);
    logic signed [VW-1:0] r;
    if (x == VMIN) r = VMAX;
    else r = -x;
    return r;
  endfunction

endpackage

/* rtl/rsa_cmac.sv */
// ----------------------------------------------------------------------------
// Complex multiply-accumulate unit
// Two stages: four partial products, then the running dot-product sum with
// rounding and saturation on the way out.
// ----------------------------------------------------------------------------
module rsa_cmac (
  input  logic              clk,
  input  logic              rst,
  input  rsa_pkg::mac_tag_t in_tag,
  input  rsa_pkg::cplx_t    a,
  input  rsa_pkg::cplx_t    b,
  output rsa_pkg::mac_tag_t res_tag,
  output rsa_pkg::cplx_t    res
);
  import rsa_pkg::*;

  mac_tag_t tag1;
  logic signed [2*VW-1:0] prr, pii, pri, pir;
  logic signed [SW-1:0] sr, si;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      res_tag <= '0;
    end else begin
      tag1    <= in_tag;
      res_tag <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    prr <= $signed(a.re) * $signed(b.re);
    pii <= $signed(a.im) * $signed(b.im);
    pri <= $signed(a.re) * $signed(b.im);
    pir <= $signed(a.im) * $signed(b.re);
    if (tag1.v) begin
      // restart the sum on the first term of each entry
      sr <= (tag1.first ? SW'(0) : sr) + SW'(prr) - SW'(pii);
      si <= (tag1.first ? SW'(0) : si) + SW'(pri) + SW'(pir);
    end
  end

  assign res.re = rnd_q(sr);
  assign res.im = rnd_q(si);

endmodule

/* rtl/rectangle_staple_accumulator.sv */
// ----------------------------------------------------------------------------
// Rectangle staple accumulator
// Sums 2x1 rectangle staples of SU(N) links into an accumulator matrix.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command per transfer:
// load a link element, load a neighbor entry, preset an accumulator
// element, or compute. Loads and presets finish in the transfer cycle.
// A compute walks each nu direction from start_direction up, skipping mu
// (up to three nu): eight neighbor lookups, then three staples of five link
// matrices; each staple loads one matrix and runs four 3x3 complex products
// through one complex multiply-accumulate unit, one term per cycle, with a
// copy after each product. The shared multiply-accumulate unit and the
// single link memory read port set the compute time.
// The output channel (out_valid / out_stall) then gives the nine elements
// row by row, last high on the final one; a stall holds the output register
// and the emission. in_stall stays high until the last element is in the
// output register. Reset clears the accumulator and the control state;
// the link and neighbor memories hold nothing defined until loaded.
// ----------------------------------------------------------------------------
`include "rectangle_staple_accumulator_assert.svh"

module rectangle_staple_accumulator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         opcode,
  input  logic                               bank,
  input  logic [1:0]                         direction,
  input  logic [7:0]                         site,
  input  logic [1:0]                         row,
  input  logic [1:0]                         col,
  input  logic signed [23:0]                 value_re,
  input  logic signed [23:0]                 value_im,
  input  logic [7:0]                         neighbor_site,
  input  logic                               neighbor_sign,
  input  logic [2:0]                         start_direction,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_row,
  output logic [1:0]                         out_col,
  output logic signed [23:0]                 out_re,
  output logic signed [23:0]                 out_im,
  output logic                               last
);
  import rsa_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_NEXTNU = 9'b000000010,
    ST_LOOKUP = 9'b000000100,
    ST_LDMAT  = 9'b000001000,
    ST_MUL    = 9'b000010000,
    ST_COPY   = 9'b000100000,
    ST_STAPLE = 9'b001000000,
    ST_ACCUM  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic       use_nu;
    logic [3:0] slot;
    logic       dag;
  } opnd_t;

  typedef struct packed {
    logic       sign;
    logic       use_nu;
    logic [3:0] src;
  } look_t;

  localparam int         NLOOK   = 8;
  localparam int         NSLOT   = NLOOK + 1;
  localparam logic [2:0] LK_LAST = 3'(NLOOK - 1);
  localparam logic [2:0] M_LAST  = 3'd4;
  localparam logic [1:0] C_LAST  = 2'd2;
  localparam logic [3:0] SLOT_X  = 4'd8;
  localparam logic [IW-1:0] N_LAST = IW'(NCOL - 1);

  // slots: 0 jmu, 1 jmm, 2 knu, 3 knumu, 4 knu2mu, 5 knumm, 6 k2nu, 7 k2numu, 8 x
  function automatic look_t look_of(input logic [2:0] idx);
    look_t r;
    unique case (idx)
      3'd0:    r = '{1'b0, 1'b0, SLOT_X};
      3'd1:    r = '{1'b1, 1'b0, SLOT_X};
      3'd2:    r = '{1'b1, 1'b1, SLOT_X};
      3'd3:    r = '{1'b0, 1'b0, 4'd2};
      3'd4:    r = '{1'b0, 1'b0, 4'd3};
      3'd5:    r = '{1'b1, 1'b0, 4'd2};
      3'd6:    r = '{1'b1, 1'b1, 4'd2};
      default: r = '{1'b0, 1'b0, 4'd6};
    endcase
    return r;
  endfunction

  // link number 1..12 of each factor in the three staple chains
  function automatic logic [3:0] link_of(input logic [1:0] ch, input logic [2:0] m);
    logic [3:0] r;
    r = 4'd1;
    unique case (ch)
      2'd0: begin
        unique case (m)
          3'd0: r = 4'd1;  3'd1: r = 4'd2;  3'd2: r = 4'd4;
          3'd3: r = 4'd5;  default: r = 4'd6;
        endcase
      end
      2'd1: begin
        unique case (m)
          3'd0: r = 4'd10; 3'd1: r = 4'd11; 3'd2: r = 4'd12;
          3'd3: r = 4'd2;  default: r = 4'd3;
        endcase
      end
      default: begin
        unique case (m)
          3'd0: r = 4'd1;  3'd1: r = 4'd7;  3'd2: r = 4'd8;
          3'd3: r = 4'd9;  default: r = 4'd3;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic opnd_t opnd_of(input logic [3:0] lnk);
    opnd_t r;
    unique case (lnk)
      4'd1:    r = '{1'b1, 4'd2, 1'b1};
      4'd2:    r = '{1'b0, 4'd2, 1'b0};
      4'd3:    r = '{1'b1, 4'd3, 1'b0};
      4'd4:    r = '{1'b0, 4'd3, 1'b0};
      4'd5:    r = '{1'b1, 4'd4, 1'b0};
      4'd6:    r = '{1'b0, 4'd0, 1'b1};
      4'd7:    r = '{1'b1, 4'd6, 1'b1};
      4'd8:    r = '{1'b0, 4'd6, 1'b0};
      4'd9:    r = '{1'b1, 4'd7, 1'b0};
      4'd10:   r = '{1'b0, 4'd1, 1'b1};
      4'd11:   r = '{1'b1, 4'd5, 1'b1};
      default: r = '{1'b0, 4'd5, 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [EW-1:0] idx(input logic [IW-1:0] i, input logic [IW-1:0] j);
    return EW'(i) * EW'(NCOL) + EW'(j);
  endfunction

  function automatic logic [LK_AW-1:0] lk_addr(input logic b, input logic [DIR_W-1:0] d,
                                               input logic [SITE_W-1:0] s,
                                               input logic [EW-1:0] e);
    return LK_AW'({b, d, s}) * LK_AW'(NSQ) + LK_AW'(e);
  endfunction

  state_t st;
  logic [2:0] nu;
  logic [DIR_W-1:0] mu;
  logic c_bank;
  logic [2:0] lk_idx;
  logic ph;
  logic [1:0] chain;
  logic [2:0] m;
  logic [IW-1:0] ci, cj, ck, ei, ej;
  logic iss_on;
  logic ld_v, ld_final;
  logic [EW-1:0] ld_dest;
  mac_tag_t tag0, mo_tag;
  cplx_t a_reg, b_val, mo_res;

  logic [SITE_W-1:0] sites [NSLOT];
  cplx_t r_mat [NSQ];
  cplx_t t_mat [NSQ];
  logic signed [SSW-1:0] s_re [NSQ];
  logic signed [SSW-1:0] s_im [NSQ];
  logic signed [VW-1:0] acc_re [NSQ];
  logic signed [VW-1:0] acc_im [NSQ];

  logic [2*VW-1:0] link_mem [2*DIM*NSITES*NSQ];
  logic [SITE_W-1:0] nb_mem [2*DIM*NSITES];
  logic [2*VW-1:0] lk_rd;
  logic [SITE_W-1:0] nb_rd;

  logic in_acc, lk_we, nb_we, ld_out, emit_last;
  logic [LK_AW-1:0] lk_raddr, lk_waddr;
  logic [NB_AW-1:0] nb_raddr, nb_waddr;
  opnd_t op;
  look_t lk;
  logic [DIR_W-1:0] op_dir, lk_dir;
  logic [EW-1:0] rd_elem;
  logic mul_issue_last, ld_issue_last;

  assign in_stall = (st != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign lk_we = in_acc && (opcode == OP_LINK) && (32'(direction) < DIM) &&
                 (32'(site) < NSITES) && (32'(row) < NCOL) && (32'(col) < NCOL);
  assign nb_we = in_acc && (opcode == OP_NBR) && (32'(direction) < DIM) &&
                 (32'(site) < NSITES);
  assign lk_waddr = lk_addr(bank, direction[DIR_W-1:0], site[SITE_W-1:0],
                            idx(row[IW-1:0], col[IW-1:0]));
  assign nb_waddr = {neighbor_sign, direction[DIR_W-1:0], site[SITE_W-1:0]};

  assign op     = opnd_of(link_of(chain, m));
  assign op_dir = op.use_nu ? nu[DIR_W-1:0] : mu;
  assign lk     = look_of(lk_idx);
  assign lk_dir = lk.use_nu ? nu[DIR_W-1:0] : mu;

  always_comb begin
    if (st == ST_LDMAT) rd_elem = op.dag ? idx(cj, ci) : idx(ci, cj);
    else                rd_elem = op.dag ? idx(cj, ck) : idx(ck, cj);
  end

  assign lk_raddr = lk_addr(c_bank, op_dir, sites[op.slot], rd_elem);
  assign nb_raddr = {lk.sign, lk_dir, sites[lk.src]};

  assign b_val.re = lk_rd[2*VW-1:VW];
  assign b_val.im = op.dag ? neg_sat(lk_rd[VW-1:0]) : lk_rd[VW-1:0];

  assign ld_issue_last  = (ci == N_LAST) && (cj == N_LAST);
  assign mul_issue_last = ld_issue_last && (ck == N_LAST);
  assign ld_out    = (st == ST_EMIT) && (!out_valid || !out_stall);
  assign emit_last = (ei == N_LAST) && (ej == N_LAST);

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr] <= {value_re, value_im};
    lk_rd <= link_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[nb_waddr] <= neighbor_site[SITE_W-1:0];
    nb_rd <= nb_mem[nb_raddr];
  end

  rsa_cmac u_cmac (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (tag0),
    .a       (a_reg),
    .b       (b_val),
    .res_tag (mo_tag),
    .res     (mo_res)
  );

  // sequencer and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      iss_on    <= 1'b0;
      ld_v      <= 1'b0;
      tag0      <= '0;
      for (int e = 0; e < NSQ; e++) begin
        acc_re[e] <= '0;
        acc_im[e] <= '0;
      end
    end else begin
      ld_v         <= (st == ST_LDMAT) && iss_on;
      ld_final     <= ld_issue_last;
      ld_dest      <= idx(ci, cj);
      tag0.v       <= (st == ST_MUL) && iss_on;
      tag0.first   <= (ck == '0);
      tag0.last    <= (ck == N_LAST);
      tag0.final_term <= mul_issue_last;
      tag0.dest    <= idx(ci, cj);
      if (ld_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            if (opcode == OP_PRESET && 32'(row) < NCOL && 32'(col) < NCOL) begin
              acc_re[idx(row[IW-1:0], col[IW-1:0])] <= value_re;
              acc_im[idx(row[IW-1:0], col[IW-1:0])] <= value_im;
            end
            if (opcode == OP_COMP) begin
              mu     <= direction[DIR_W-1:0];
              c_bank <= bank;
              nu     <= start_direction;
              ei     <= '0;
              ej     <= '0;
              st     <= (32'(direction) < DIM) ? ST_NEXTNU : ST_EMIT;
            end
          end
        end
        ST_NEXTNU: begin
          if (32'(nu) >= DIM) begin
            ei <= '0;
            ej <= '0;
            st <= ST_EMIT;
          end else if (nu == 3'(mu)) begin
            nu <= nu + 3'd1;
          end else begin
            lk_idx <= '0;
            ph     <= 1'b0;
            st     <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          ph <= !ph;
          if (ph) begin
            if (lk_idx == LK_LAST) begin
              chain  <= '0;
              m      <= '0;
              ci     <= '0;
              cj     <= '0;
              ck     <= '0;
              iss_on <= 1'b1;
              st     <= ST_LDMAT;
            end else begin
              lk_idx <= lk_idx + 3'd1;
            end
          end
        end
        ST_LDMAT: begin
          if (iss_on) begin
            if (cj == N_LAST) begin
              cj <= '0;
              ci <= ci + IW'(1);
            end else begin
              cj <= cj + IW'(1);
            end
            if (ld_issue_last) iss_on <= 1'b0;
          end
          if (ld_v && ld_final) begin
            m      <= 3'd1;
            ci     <= '0;
            cj     <= '0;
            ck     <= '0;
            iss_on <= 1'b1;
            st     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (iss_on) begin
            if (ck == N_LAST) begin
              ck <= '0;
              if (cj == N_LAST) begin
                cj <= '0;
                ci <= ci + IW'(1);
              end else begin
                cj <= cj + IW'(1);
              end
            end else begin
              ck <= ck + IW'(1);
            end
            if (mul_issue_last) iss_on <= 1'b0;
          end
          if (mo_tag.v && mo_tag.final_term) st <= ST_COPY;
        end
        ST_COPY: begin
          if (m == M_LAST) begin
            st <= ST_STAPLE;
          end else begin
            m      <= m + 3'd1;
            ci     <= '0;
            cj     <= '0;
            ck     <= '0;
            iss_on <= 1'b1;
            st     <= ST_MUL;
          end
        end
        ST_STAPLE: begin
          if (chain == C_LAST) begin
            st <= ST_ACCUM;
          end else begin
            chain  <= chain + 2'd1;
            m      <= '0;
            ci     <= '0;
            cj     <= '0;
            ck     <= '0;
            iss_on <= 1'b1;
            st     <= ST_LDMAT;
          end
        end
        ST_ACCUM: begin
          for (int e = 0; e < NSQ; e++) begin
            acc_re[e] <= sat_q(SW'(acc_re[e]) + SW'(s_re[e]));
            acc_im[e] <= sat_q(SW'(acc_im[e]) + SW'(s_im[e]));
          end
          nu <= nu + 3'd1;
          st <= ST_NEXTNU;
        end
        ST_EMIT: begin
          if (ld_out) begin
            if (ej == N_LAST) begin
              ej <= '0;
              ei <= ei + IW'(1);
            end else begin
              ej <= ej + IW'(1);
            end
            if (emit_last) st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // datapath storage
  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_COMP) sites[SLOT_X] <= site[SITE_W-1:0];
    if (st == ST_LOOKUP && ph) sites[4'(lk_idx)] <= nb_rd;
    a_reg <= r_mat[idx(ci, ck)];
    if (ld_v) r_mat[ld_dest] <= b_val;
    if (mo_tag.v && mo_tag.last) t_mat[mo_tag.dest] <= mo_res;
    if (st == ST_COPY) begin
      for (int e = 0; e < NSQ; e++) r_mat[e] <= t_mat[e];
    end
    if (st == ST_STAPLE) begin
      for (int e = 0; e < NSQ; e++) begin
        s_re[e] <= (chain == '0 ? SSW'(0) : s_re[e]) + SSW'(r_mat[e].re);
        s_im[e] <= (chain == '0 ? SSW'(0) : s_im[e]) + SSW'(r_mat[e].im);
      end
    end
    if (ld_out) begin
      out_row <= 2'(ei);
      out_col <= 2'(ej);
      out_re  <= acc_re[idx(ei, ej)];
      out_im  <= acc_im[idx(ei, ej)];
      last    <= emit_last;
    end
  end

  `RSA_ASSERT(a_copy_after_mul, clk, rst, (st == ST_COPY) |-> $past(st == ST_MUL), "copy without product")
  `RSA_ASSERT(a_staple_after_chain, clk, rst, (st == ST_STAPLE) |-> ($past(st == ST_COPY) && ($past(m) == M_LAST)), "staple before chain end")
  `RSA_ASSERT_NEXT(a_emit_done, clk, rst, ld_out && emit_last, st == ST_IDLE, "emission not closed")

endmodule
